FILE: sv/mcm_pkg.sv
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared widths, register indexes, constants and the controller command
// bundle for the magnetometer correction and monitor block.
// ----------------------------------------------------------------------------
package mcm_pkg;

	localparam int RAW_W        = 16;
	localparam int SCALE_W      = 15;
	localparam int MAG_W        = 16;
	localparam int RATIO_W      = 16;
	localparam int FILT_W       = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int NUM_AXES     = 3;
	localparam int CNT_W        = 4;

	localparam int STUCK_LIMIT_DEF = 50;

	localparam int SQRT_STEPS   = MAG_W;
	localparam int DIV_STEPS    = RATIO_W;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	typedef logic [1:0]           axis_t;

	localparam reg_idx_t REG_OFFSET_X        = 3'd0;
	localparam reg_idx_t REG_OFFSET_Y        = 3'd1;
	localparam reg_idx_t REG_OFFSET_Z        = 3'd2;
	localparam reg_idx_t REG_SCALE_X         = 3'd3;
	localparam reg_idx_t REG_SCALE_Y         = 3'd4;
	localparam reg_idx_t REG_SCALE_Z         = 3'd5;
	localparam reg_idx_t REG_EARTH_MAGNITUDE = 3'd6;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	localparam logic [SCALE_W-1:0] SCALE_ONE     = 15'd16384;
	localparam logic [MAG_W-1:0]   EARTH_MAG_DEF = 16'd4000;

	// Division by 100 as a multiplication by ceil(2^37 / 100).
	localparam logic [15:0] DIV100_MUL_LO = 16'h851F;
	localparam logic [15:0] DIV100_MUL_HI = 16'h51EB;
	localparam int          DIV100_SHIFT  = 37;
	localparam logic [6:0]  FILT_KEEP     = 7'd99;

	typedef struct packed {
		logic  load;
		logic  mul_en;
		logic  mul_sq;
		axis_t mul_axis;
		logic  wr_en;
		axis_t wr_axis;
		logic  acc_en;
		logic  sqrt_en;
		logic  sqrt_first;
		logic  div_en;
		logic  div_first;
		logic  flt_sum;
		logic  flt_lo;
		logic  flt_hi;
		logic  flt_upd;
		logic  out_load;
	} mcm_cmd_t;

endpackage

FILE: sv/mcm_sample_if.sv
// ----------------------------------------------------------------------------
// mcm_sample_if
// Input channel: one raw three-axis magnetometer sample per item.
// ----------------------------------------------------------------------------
interface mcm_sample_if;
	logic                               valid;
	logic                               ready;
	logic signed [mcm_pkg::RAW_W-1:0]   raw_x;
	logic signed [mcm_pkg::RAW_W-1:0]   raw_y;
	logic signed [mcm_pkg::RAW_W-1:0]   raw_z;

	modport source (output valid, raw_x, raw_y, raw_z, input ready);
	modport sink (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

FILE: sv/mcm_result_if.sv
// ----------------------------------------------------------------------------
// mcm_result_if
// Output channel: corrected field, filtered magnitude ratio and stuck flag.
// ----------------------------------------------------------------------------
interface mcm_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [mcm_pkg::RAW_W-1:0]   field_x;
	logic signed [mcm_pkg::RAW_W-1:0]   field_y;
	logic signed [mcm_pkg::RAW_W-1:0]   field_z;
	logic [mcm_pkg::RATIO_W-1:0]        field_ratio;
	logic                               sensor_stuck;

	modport source (output valid, field_x, field_y, field_z, field_ratio, sensor_stuck,
		input ready);
	modport sink (input valid, field_x, field_y, field_z, field_ratio, sensor_stuck,
		output ready);
endinterface

FILE: sv/mcm_cfg_if.sv
// ----------------------------------------------------------------------------
// mcm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mcm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mcm_pkg::CFG_IDX_W-1:0]     index;
	logic [mcm_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/magnetometer_correct_and_monitor.sv
// ----------------------------------------------------------------------------
// magnetometer_correct_and_monitor
// Hard and soft iron correction of a three-axis sample, with a filtered
// field magnitude ratio and a stuck-sensor flag.
// ----------------------------------------------------------------------------
// An accepted item passes through correction, sum of squares, the serial square
// root, the bit-serial divider, the filter and the output load, which waits
// while the output register holds a result not yet taken. A new item is taken
// only in idle, and the output register lets it start while a result waits.
// Reset clears the previous sample, the repeat count and the filter, and loads
// the register defaults. Configuration writes are taken in every cycle.
module magnetometer_correct_and_monitor #(
	parameter int STUCK_LIMIT = mcm_pkg::STUCK_LIMIT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mcm_sample_if.sink   sample,
	mcm_result_if.source result,
	mcm_cfg_if.sink      cfg
);
	import mcm_pkg::*;

	mcm_cmd_t cmd;

	assign cfg.ready = 1'b1;

	mcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	mcm_dp #(
		.STUCK_LIMIT (STUCK_LIMIT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.raw_x        (sample.raw_x),
		.raw_y        (sample.raw_y),
		.raw_z        (sample.raw_z),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.field_x      (result.field_x),
		.field_y      (result.field_y),
		.field_z      (result.field_z),
		.field_ratio  (result.field_ratio),
		.sensor_stuck (result.sensor_stuck)
	);

endmodule

FILE: sv/mcm_ctrl.sv
// ----------------------------------------------------------------------------
// mcm_ctrl
// Sequencer: steps the datapath through correction, sum of squares, square
// root, ratio division and filter update, then hands the item to the output.
// ----------------------------------------------------------------------------
module mcm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mcm_pkg::mcm_cmd_t cmd
);
	import mcm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_COR  = 3'd1;
	localparam logic [2:0] S_SQ   = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FLT  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	localparam logic [CNT_W-1:0] PASS_LAST = CNT_W'(NUM_AXES);
	localparam logic [CNT_W-1:0] FLT_LAST  = 4'd3;
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		cnt_d    = cnt_q + 1'b1;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cnt_d    = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_COR;
				end
			end
			S_COR: begin
				cmd.mul_en   = (cnt_q != PASS_LAST);
				cmd.mul_axis = cnt_q[1:0];
				cmd.wr_en    = (cnt_q != '0);
				cmd.wr_axis  = cnt_q[1:0] - 2'd1;
				if (cnt_q == PASS_LAST) begin
					state_d = S_SQ;
					cnt_d   = '0;
				end
			end
			S_SQ: begin
				cmd.mul_en   = (cnt_q != PASS_LAST);
				cmd.mul_sq   = 1'b1;
				cmd.mul_axis = cnt_q[1:0];
				cmd.acc_en   = (cnt_q != '0);
				if (cnt_q == PASS_LAST) begin
					state_d = S_SQRT;
					cnt_d   = '0;
				end
			end
			S_SQRT: begin
				cmd.sqrt_en    = 1'b1;
				cmd.sqrt_first = (cnt_q == '0);
				if (cnt_q == SQRT_LAST) begin
					state_d = S_DIV;
					cnt_d   = '0;
				end
			end
			S_DIV: begin
				cmd.div_en    = 1'b1;
				cmd.div_first = (cnt_q == '0);
				if (cnt_q == DIV_LAST) begin
					state_d = S_FLT;
					cnt_d   = '0;
				end
			end
			S_FLT: begin
				cmd.flt_sum = (cnt_q == 4'd0);
				cmd.flt_lo  = (cnt_q == 4'd1);
				cmd.flt_hi  = (cnt_q == 4'd2);
				cmd.flt_upd = (cnt_q == FLT_LAST);
				if (cnt_q == FLT_LAST) begin
					state_d = S_OUT;
					cnt_d   = '0;
				end
			end
			S_OUT: begin
				cnt_d = '0;
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_COR && cnt_q == '0))
		else $error("accepted item did not start the correction pass");

	a_div_after_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == '0) |-> ($past(state_q) == S_SQRT))
		else $error("division started without a finished square root");

	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COR || state_q == S_SQ || state_q == S_FLT) |-> (cnt_q <= PASS_LAST))
		else $error("step counter ran past a short pass");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while holding an item");

endmodule

FILE: sv/mcm_dp.sv
// ----------------------------------------------------------------------------
// mcm_dp
// Datapath: configuration registers, stuck detector, shared axis multiplier,
// digit-serial square root, bit-serial ratio divider, low-pass filter and
// output register.
// ----------------------------------------------------------------------------
module mcm_dp #(
	parameter int STUCK_LIMIT = mcm_pkg::STUCK_LIMIT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mcm_pkg::mcm_cmd_t                     cmd,
	input  logic signed [mcm_pkg::RAW_W-1:0]      raw_x,
	input  logic signed [mcm_pkg::RAW_W-1:0]      raw_y,
	input  logic signed [mcm_pkg::RAW_W-1:0]      raw_z,
	input  logic                                  cfg_valid,
	input  logic [mcm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mcm_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic signed [mcm_pkg::RAW_W-1:0]      field_x,
	output logic signed [mcm_pkg::RAW_W-1:0]      field_y,
	output logic signed [mcm_pkg::RAW_W-1:0]      field_z,
	output logic [mcm_pkg::RATIO_W-1:0]           field_ratio,
	output logic                                  sensor_stuck
);
	import mcm_pkg::*;

	localparam int REP_W = $clog2(STUCK_LIMIT + 2);
	localparam logic [REP_W-1:0] REP_LIMIT = REP_W'(STUCK_LIMIT);

	// Configuration.
	logic signed [RAW_W-1:0] off_q [NUM_AXES];
	logic [SCALE_W-1:0]      scl_q [NUM_AXES];
	logic [MAG_W-1:0]        em_q;

	// Sample, stuck detector.
	logic signed [RAW_W-1:0] raw_q  [NUM_AXES];
	logic signed [RAW_W-1:0] prev_q [NUM_AXES];
	logic [REP_W-1:0]        rep_q, rep_d;
	logic                    stuck_q;
	logic                    same;

	// Correction and sum of squares.
	logic signed [RAW_W-1:0] fld_q [NUM_AXES];
	logic signed [RAW_W:0]   mul_a;
	logic signed [RAW_W-1:0] mul_b;
	logic signed [32:0]      mul_p;
	logic signed [32:0]      prod_q;
	logic signed [18:0]      cor_sh;
	logic signed [RAW_W-1:0] cor_sat;
	logic [31:0]             acc_q;

	// Square root.
	logic [31:0]     rad_q, rad_in;
	logic [16:0]     rem_q, rem_in;
	logic [MAG_W-1:0] root_q, root_in;
	logic [18:0]     rem_try, rem_trial;
	logic            sq_ge;

	// Ratio division.
	logic               ovf_q;
	logic [MAG_W-1:0]   drem_q, drem_in;
	logic [RATIO_W-1:0] dnum_q, dnum_in;
	logic [RATIO_W-1:0] quot_q, quot_in;
	logic [MAG_W:0]     dtry;
	logic               dv_ge;
	logic [RATIO_W-1:0] ratio;

	// Filter.
	logic [31:0]       x_q;
	logic [47:0]       plo_q, phi_q, pmul;
	logic [63:0]       ptot;
	logic [FILT_W-1:0] filt_q;

	// Output register.
	logic signed [RAW_W-1:0] ofld_q [NUM_AXES];
	logic [RATIO_W-1:0]      oratio_q;
	logic                    ostuck_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q[AXIS_X] <= '0;
			off_q[AXIS_Y] <= '0;
			off_q[AXIS_Z] <= '0;
			scl_q[AXIS_X] <= SCALE_ONE;
			scl_q[AXIS_Y] <= SCALE_ONE;
			scl_q[AXIS_Z] <= SCALE_ONE;
			em_q          <= EARTH_MAG_DEF;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OFFSET_X:        off_q[AXIS_X] <= $signed(cfg_data);
				REG_OFFSET_Y:        off_q[AXIS_Y] <= $signed(cfg_data);
				REG_OFFSET_Z:        off_q[AXIS_Z] <= $signed(cfg_data);
				REG_SCALE_X:         scl_q[AXIS_X] <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Y:         scl_q[AXIS_Y] <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Z:         scl_q[AXIS_Z] <= cfg_data[SCALE_W-1:0];
				REG_EARTH_MAGNITUDE: em_q <= cfg_data[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	assign same = (raw_x == prev_q[AXIS_X]) && (raw_y == prev_q[AXIS_Y]) &&
		(raw_z == prev_q[AXIS_Z]);

	always_comb begin
		if (!same) begin
			rep_d = '0;
		end else if (rep_q <= REP_LIMIT) begin
			rep_d = rep_q + 1'b1;
		end else begin
			rep_d = rep_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q[AXIS_X] <= '0;
			prev_q[AXIS_Y] <= '0;
			prev_q[AXIS_Z] <= '0;
			rep_q          <= '0;
			stuck_q        <= 1'b0;
			filt_q         <= '0;
		end else begin
			if (cmd.load) begin
				prev_q[AXIS_X] <= raw_x;
				prev_q[AXIS_Y] <= raw_y;
				prev_q[AXIS_Z] <= raw_z;
				rep_q          <= rep_d;
				stuck_q        <= (rep_d > REP_LIMIT);
			end
			if (cmd.flt_upd) begin
				filt_q <= ptot[DIV100_SHIFT +: FILT_W];
			end
		end
	end

	// Shared multiplier: (raw - offset) * scale, or a corrected axis squared.
	always_comb begin
		if (cmd.mul_sq) begin
			mul_a = (RAW_W+1)'(fld_q[cmd.mul_axis]);
			mul_b = fld_q[cmd.mul_axis];
		end else begin
			mul_a = (RAW_W+1)'(raw_q[cmd.mul_axis]) - (RAW_W+1)'(off_q[cmd.mul_axis]);
			mul_b = $signed({1'b0, scl_q[cmd.mul_axis]});
		end
		mul_p = mul_a * mul_b;
	end

	// The arithmetic shift gives floor rounding; then saturate to 16 bits.
	assign cor_sh = prod_q[32:14];
	always_comb begin
		if (cor_sh[18:15] != {4{cor_sh[15]}}) begin
			cor_sat = cor_sh[18] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			cor_sat = cor_sh[15:0];
		end
	end

	// One result bit of the square root per step.
	always_comb begin
		rad_in    = cmd.sqrt_first ? acc_q : rad_q;
		rem_in    = cmd.sqrt_first ? '0 : rem_q;
		root_in   = cmd.sqrt_first ? '0 : root_q;
		rem_try   = {rem_in, rad_in[31:30]};
		rem_trial = {1'b0, root_in, 2'b01};
		sq_ge     = (rem_try >= rem_trial);
	end

	// One quotient bit of (root * 16384) / earth_magnitude per step.
	always_comb begin
		drem_in = cmd.div_first ? {2'b00, root_q[MAG_W-1:2]} : drem_q;
		dnum_in = cmd.div_first ? {root_q[1:0], 14'd0} : dnum_q;
		quot_in = cmd.div_first ? '0 : quot_q;
		dtry    = {drem_in, dnum_in[RATIO_W-1]};
		dv_ge   = (dtry >= {1'b0, em_q});
	end

	assign ratio = ovf_q ? '1 : quot_q;
	assign pmul  = 48'(x_q) * 48'(cmd.flt_lo ? DIV100_MUL_LO : DIV100_MUL_HI);
	assign ptot  = {phi_q, 16'd0} + {16'd0, plo_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q[AXIS_X] <= raw_x;
			raw_q[AXIS_Y] <= raw_y;
			raw_q[AXIS_Z] <= raw_z;
			acc_q         <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + prod_q[31:0];
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.wr_en) begin
			fld_q[cmd.wr_axis] <= cor_sat;
		end
		if (cmd.sqrt_en) begin
			rad_q  <= {rad_in[29:0], 2'b00};
			rem_q  <= sq_ge ? 17'(rem_try - rem_trial) : rem_try[16:0];
			root_q <= {root_in[MAG_W-2:0], sq_ge};
		end
		if (cmd.div_en) begin
			if (cmd.div_first) begin
				ovf_q <= ({2'b00, root_q} >= {em_q, 2'b00});
			end
			drem_q <= dv_ge ? MAG_W'(dtry - {1'b0, em_q}) : dtry[MAG_W-1:0];
			dnum_q <= {dnum_in[RATIO_W-2:0], 1'b0};
			quot_q <= {quot_in[RATIO_W-2:0], dv_ge};
		end
		if (cmd.flt_sum) begin
			x_q <= 32'(filt_q) * 32'(FILT_KEEP) + 32'({ratio, 8'd0});
		end
		if (cmd.flt_lo) begin
			plo_q <= pmul;
		end
		if (cmd.flt_hi) begin
			phi_q <= pmul;
		end
		if (cmd.out_load) begin
			ofld_q[AXIS_X] <= fld_q[AXIS_X];
			ofld_q[AXIS_Y] <= fld_q[AXIS_Y];
			ofld_q[AXIS_Z] <= fld_q[AXIS_Z];
			oratio_q       <= filt_q[FILT_W-1 -: RATIO_W];
			ostuck_q       <= stuck_q;
		end
	end

	assign field_x      = ofld_q[AXIS_X];
	assign field_y      = ofld_q[AXIS_Y];
	assign field_z      = ofld_q[AXIS_Z];
	assign field_ratio  = oratio_q;
	assign sensor_stuck = ostuck_q;

	a_rep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q <= REP_W'(STUCK_LIMIT + 1))
		else $error("repeat count passed its saturation value");

	a_stuck_match: assert property (@(posedge clk) disable iff (!arst_n)
		stuck_q == (rep_q > REP_LIMIT))
		else $error("stuck flag disagrees with the repeat count");

	a_zero_mag_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_first && em_q == '0) |=> ovf_q)
		else $error("zero expected magnitude did not saturate the ratio");

endmodule

FILE: verif/magnetometer_correct_and_monitor_tb.sv
// ----------------------------------------------------------------------------
// magnetometer_correct_and_monitor_tb
// Self-checking bench for the magnetometer correction and monitor block. A
// short stimulus table covers the axis extremes, saturation, a zero and the
// extreme field magnitudes, an ignored register write and the all-zero first
// sample. Random phases follow, each with fresh calibration, mixing realistic
// samples, full-range noise and long runs of repeated samples for the stuck
// flag. Results are checked against an in-bench datapath model or typed values.
// ----------------------------------------------------------------------------
module magnetometer_correct_and_monitor_tb;
	import mcm_pkg::*;

	localparam int       STUCK_LIMIT  = STUCK_LIMIT_DEF;
	localparam reg_idx_t REG_UNUSED   = 3'd7;
	localparam int       PHASES       = 8;
	localparam int       PHASE_ITEMS  = 240;
	localparam int       HOLD_AT      = 400;
	localparam int       HOLD_CYCLES  = 1500;
	localparam int       QUIET_FROM   = 1000;
	localparam int       QUIET_TO     = 1240;
	localparam int       DRAIN_CYCLES = 60;
	localparam int       MAX_REPORTS  = 10;

	typedef struct packed {
		logic signed [RAW_W-1:0] x, y, z;
	} raw_sample_t;

	typedef struct packed {
		logic signed [RAW_W-1:0] x, y, z;
		logic [RATIO_W-1:0]      ratio;
		logic                    stuck;
	} field_report_t;

	typedef enum logic {ROW_REG_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		reg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		raw_sample_t           smp;
		logic                  typed;
		field_report_t         want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mcm_sample_if sample ();
	mcm_result_if result ();
	mcm_cfg_if    cfg ();

	magnetometer_correct_and_monitor #(
		.STUCK_LIMIT(STUCK_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result),
		.cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic signed [RAW_W-1:0] off_x, off_y, off_z;
	logic [SCALE_W-1:0]      gain_x, gain_y, gain_z;
	logic [MAG_W-1:0]        earth_mag;
	raw_sample_t             last_raw;
	int unsigned             repeat_run;
	logic [FILT_W-1:0]       ratio_acc;

	field_report_t pending_fields[$];
	int            items_sent;
	int            results_checked;
	int            mismatches;

	function automatic logic signed [RAW_W-1:0] correct_axis(logic signed [RAW_W-1:0] raw,
		logic signed [RAW_W-1:0] off, logic [SCALE_W-1:0] gain);
		longint prod;
		longint q;
		prod = (longint'(raw) - longint'(off)) * longint'(gain);
		q = prod >>> 14;
		if (q > 32767) begin
			q = 32767;
		end else if (q < -32768) begin
			q = -32768;
		end
		return q[RAW_W-1:0];
	endfunction

	function automatic logic [31:0] isqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'h1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root[31:0];
	endfunction

	function automatic void apply_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_OFFSET_X:        off_x = data;
			REG_OFFSET_Y:        off_y = data;
			REG_OFFSET_Z:        off_z = data;
			REG_SCALE_X:         gain_x = data[SCALE_W-1:0];
			REG_SCALE_Y:         gain_y = data[SCALE_W-1:0];
			REG_SCALE_Z:         gain_z = data[SCALE_W-1:0];
			REG_EARTH_MAGNITUDE: earth_mag = data;
			default: ;
		endcase
	endfunction

	function automatic field_report_t correct_and_monitor(raw_sample_t s);
		field_report_t   f;
		longint unsigned sum;
		longint unsigned q;
		logic [31:0]     mag;
		logic [RATIO_W-1:0] ratio_now;
		longint unsigned acc;
		if (s == last_raw) begin
			if (repeat_run < STUCK_LIMIT + 1)
				repeat_run++;
		end else begin
			repeat_run = 0;
		end
		last_raw = s;
		f.stuck = repeat_run > STUCK_LIMIT;
		f.x = correct_axis(s.x, off_x, gain_x);
		f.y = correct_axis(s.y, off_y, gain_y);
		f.z = correct_axis(s.z, off_z, gain_z);
		sum = longint'(f.x) * longint'(f.x) + longint'(f.y) * longint'(f.y)
			+ longint'(f.z) * longint'(f.z);
		mag = isqrt(sum);
		if (earth_mag == 0) begin
			ratio_now = 16'hFFFF;
		end else begin
			q = (longint'(mag) * 16384) / longint'(earth_mag);
			ratio_now = (q > 65535) ? 16'hFFFF : q[RATIO_W-1:0];
		end
		acc = (longint'(ratio_acc) * 99 + longint'(ratio_now) * 256) / 100;
		ratio_acc = acc[FILT_W-1:0];
		f.ratio = ratio_acc[FILT_W-1:8];
		return f;
	endfunction

	function automatic stim_row_t reg_row(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r = '{ROW_REG_WRITE, idx, data, '0, 1'b0, '0};
		return r;
	endfunction

	function automatic stim_row_t sample_row(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		stim_row_t r;
		r = '{ROW_SAMPLE, REG_OFFSET_X, '0, {x, y, z}, 1'b0, '0};
		return r;
	endfunction

	function automatic stim_row_t typed_row(logic [15:0] x, logic [15:0] y, logic [15:0] z,
		field_report_t want);
		stim_row_t r;
		r = '{ROW_SAMPLE, REG_OFFSET_X, '0, {x, y, z}, 1'b1, want};
		return r;
	endfunction

	function automatic logic [15:0] extreme_value();
		case ($urandom_range(0, 3))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic raw_sample_t next_raw();
		raw_sample_t s;
		case ($urandom_range(0, 9))
			0: s = {16'($urandom), 16'($urandom), 16'($urandom)};
			1: s = {extreme_value(), extreme_value(), extreme_value()};
			default: begin
				s.x = off_x + 16'($urandom_range(0, 12000)) - 16'd6000;
				s.y = off_y + 16'($urandom_range(0, 12000)) - 16'd6000;
				s.z = off_z + 16'($urandom_range(0, 12000)) - 16'd6000;
			end
		endcase
		return s;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		apply_reg(idx, data);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(raw_sample_t s, logic typed, field_report_t want);
		field_report_t predicted;
		sample.valid <= 1'b1;
		sample.raw_x <= s.x;
		sample.raw_y <= s.y;
		sample.raw_z <= s.z;
		do @(posedge clk); while (!sample.ready);
		predicted = correct_and_monitor(s);
		pending_fields.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	task automatic maybe_idle();
		bit busy_stretch;
		busy_stretch = items_sent >= QUIET_FROM && items_sent < QUIET_TO;
		if (!busy_stretch && $urandom_range(0, 99) < 16) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 50)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		sample.valid <= 1'b0;
		while (pending_fields.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic program_phase(int phase);
		reg_idx_t    idx;
		logic [15:0] val;
		for (int i = int'(REG_OFFSET_X); i <= int'(REG_EARTH_MAGNITUDE); i++) begin
			idx = reg_idx_t'(i);
			if (idx <= REG_OFFSET_Z) begin
				if (phase == 0)
					val = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
				else if (phase == PHASES - 1)
					val = '0;
				else if ($urandom_range(0, 7) < 3)
					val = extreme_value();
				else
					val = 16'($urandom_range(0, 6000)) - 16'd3000;
			end else if (idx <= REG_SCALE_Z) begin
				if (phase == 0)
					val = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
				else if (phase == PHASES - 1)
					val = 16'(SCALE_ONE);
				else case ($urandom_range(0, 7))
					0:       val = 16'h0000;
					1:       val = 16'h7FFF;
					2:       val = 16'(SCALE_ONE);
					default: val = 16'($urandom_range(10000, 26000))
						| 16'($urandom_range(0, 1) << 15);
				endcase
			end else begin
				if (phase == 0)
					val = $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
				else if (phase == PHASES - 1)
					val = EARTH_MAG_DEF;
				else case ($urandom_range(0, 7))
					0:       val = 16'h0000;
					1:       val = 16'h0001;
					2:       val = 16'hFFFF;
					3:       val = EARTH_MAG_DEF;
					default: val = 16'($urandom_range(300, 30000));
				endcase
			end
			write_reg(idx, val);
		end
		if (phase % 2 == 1)
			write_reg(REG_UNUSED, 16'($urandom));
	endtask

	task automatic check_result();
		field_report_t got;
		field_report_t want;
		got = {result.field_x, result.field_y, result.field_z, result.field_ratio,
			result.sensor_stuck};
		results_checked++;
		if (pending_fields.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("unexpected result %0d: x=%0d y=%0d z=%0d ratio=%0d stuck=%0b",
					results_checked, got.x, got.y, got.z, got.ratio, got.stuck);
		end else begin
			want = pending_fields.pop_front();
			if (got != want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$write("mismatch on result %0d: expected x=%0d y=%0d z=%0d ratio=%0d ",
						results_checked, want.x, want.y, want.z, want.ratio);
					$display("stuck=%0b, got x=%0d y=%0d z=%0d ratio=%0d stuck=%0b",
						want.stuck, got.x, got.y, got.z, got.ratio, got.stuck);
				end
			end
		end
	endtask

	initial begin
		int  hold_left;
		bit  hold_done;
		bit  quiet;
		hold_left = 0;
		hold_done = 1'b0;
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result.valid && result.ready)
				check_result();
			quiet = results_checked >= QUIET_FROM && results_checked < QUIET_TO;
			if (hold_left != 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else if (!hold_done && results_checked >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				result.ready <= 1'b0;
			end else begin
				result.ready <= quiet || $urandom_range(0, 99) >= 16;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		stim_row_t   rows[$];
		raw_sample_t s;
		int          n;
		int          burst;
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.raw_x = '0;
		sample.raw_y = '0;
		sample.raw_z = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_OFFSET_X;
		cfg.data = '0;
		off_x = '0;
		off_y = '0;
		off_z = '0;
		gain_x = SCALE_ONE;
		gain_y = SCALE_ONE;
		gain_z = SCALE_ONE;
		earth_mag = EARTH_MAG_DEF;
		last_raw = '0;
		repeat_run = 0;
		ratio_acc = '0;
		items_sent = 0;
		results_checked = 0;
		mismatches = 0;

		// An all-zero sample right after reset repeats the cleared previous sample.
		rows.push_back(typed_row(16'h0000, 16'h0000, 16'h0000, '0));
		rows.push_back(typed_row(16'h0000, 16'h0000, 16'h0000, '0));
		rows.push_back(sample_row(16'h7FFF, 16'h8000, 16'h0000));
		rows.push_back(sample_row(16'h8000, 16'h7FFF, 16'hFFFF));
		rows.push_back(sample_row(16'h0001, 16'hFFFE, 16'h4000));
		rows.push_back(reg_row(REG_OFFSET_X, 16'h7FFF));
		rows.push_back(reg_row(REG_OFFSET_Y, 16'h8000));
		rows.push_back(reg_row(REG_OFFSET_Z, 16'h0001));
		rows.push_back(reg_row(REG_SCALE_X, 16'h7FFF));
		rows.push_back(reg_row(REG_SCALE_Y, 16'h7FFF));
		rows.push_back(reg_row(REG_SCALE_Z, 16'hFFFF));
		rows.push_back(sample_row(16'h8000, 16'h7FFF, 16'h7FFF));
		rows.push_back(sample_row(16'h7FFF, 16'h8000, 16'h8000));
		rows.push_back(sample_row(16'h0000, 16'h0000, 16'h0000));
		rows.push_back(reg_row(REG_EARTH_MAGNITUDE, 16'h0000));
		rows.push_back(sample_row(16'h0064, 16'h00C8, 16'h012C));
		rows.push_back(sample_row(16'h8000, 16'h8000, 16'h8000));
		rows.push_back(reg_row(REG_UNUSED, 16'h1234));
		rows.push_back(sample_row(16'h0001, 16'h0002, 16'h0003));
		rows.push_back(reg_row(REG_EARTH_MAGNITUDE, 16'h0001));
		rows.push_back(sample_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
		rows.push_back(sample_row(16'h0000, 16'h0000, 16'h0000));
		rows.push_back(reg_row(REG_EARTH_MAGNITUDE, 16'hFFFF));
		rows.push_back(sample_row(16'h8000, 16'h7FFF, 16'h8000));
		rows.push_back(sample_row(16'h0001, 16'h0001, 16'h0001));
		rows.push_back(reg_row(REG_OFFSET_X, 16'h0000));
		rows.push_back(reg_row(REG_OFFSET_Y, 16'h0000));
		rows.push_back(reg_row(REG_OFFSET_Z, 16'h0000));
		rows.push_back(reg_row(REG_SCALE_X, 16'(SCALE_ONE)));
		rows.push_back(reg_row(REG_SCALE_Y, 16'(SCALE_ONE)));
		rows.push_back(reg_row(REG_SCALE_Z, 16'(SCALE_ONE)));
		rows.push_back(reg_row(REG_EARTH_MAGNITUDE, EARTH_MAG_DEF));
		rows.push_back(sample_row(16'h0FA0, 16'h0000, 16'h0000));
		rows.push_back(sample_row(16'hFFFF, 16'hFFFF, 16'hFFFF));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_REG_WRITE) begin
				wait_idle();
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				send_sample(rows[i].smp, rows[i].typed, rows[i].want);
				maybe_idle();
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			program_phase(phase);
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 3) begin
					burst = $urandom_range(1, 90);
					s = last_raw;
				end else begin
					burst = 1;
					s = next_raw();
				end
				for (int k = 0; k < burst && n < PHASE_ITEMS; k++) begin
					if (burst > 1 && $urandom_range(0, 99) < 2)
						send_sample(next_raw(), 1'b0, '0);
					else
						send_sample(s, 1'b0, '0);
					maybe_idle();
					n++;
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_fields.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/mcm_pkg.sv
sv/mcm_sample_if.sv
sv/mcm_result_if.sv
sv/mcm_cfg_if.sv
sv/mcm_ctrl.sv
sv/mcm_dp.sv
sv/magnetometer_correct_and_monitor.sv
verif/magnetometer_correct_and_monitor_tb.sv
